/* sv/stt_pkg.sv */
// Shared types and codes for the software timer table.
// Used by stt_div, stt_seq and software_timer_table.
package stt_pkg;

    localparam int DEFAULT_SLOTS = 16;
    localparam int TICK_W        = 32;
    localparam int TASK_W        = 8;
    localparam int REF_W         = 16;
    localparam int DUR_W         = 32;
    localparam int RES_W         = 16;
    localparam int EV_W          = 3;
    localparam int CMD_W         = 2;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

    localparam logic [EV_W-1:0] EV_STARTED   = 3'd0;
    localparam logic [EV_W-1:0] EV_FULL      = 3'd1;
    localparam logic [EV_W-1:0] EV_CANCELLED = 3'd2;
    localparam logic [EV_W-1:0] EV_NOTFOUND  = 3'd3;
    localparam logic [EV_W-1:0] EV_EXPIRED   = 3'd4;

    localparam logic [RES_W-1:0] RES_RESET = 16'd1;

    typedef struct packed {
        logic [TICK_W-1:0] expiry;
        logic [TASK_W-1:0] task_id;
        logic [REF_W-1:0]  timer_ref;
    } entry_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [TASK_W-1:0] owner_task;
        logic [REF_W-1:0]  owner_ref;
        logic              last;
    } res_t;

endpackage

/* sv/software_timer_table.sv */
// Software timer table: holds the resolution register and the result output register.
// Depends on stt_pkg and stt_seq (which uses stt_ram and stt_div).
// Tick reads and checks every slot, then walks the matches and reports each expired entry;
// start divides the duration by the resolution, then looks for a free slot; cancel reads
// and checks slots until a match; output stalls hold any report. Takes one item at a time.
// Reset: tick count zero, table empty, resolution 1; no clearing pass over the RAM.
module software_timer_table #(
    parameter int TIMER_SLOTS = stt_pkg::DEFAULT_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // tick_resolution_ms
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // task_id[7:0], timer_ref[23:8], duration_ms[55:24]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // owner_task[7:0], owner_ref[23:8]
    output logic [2:0]  m_axis_tuser,   // event_res[2:0]
    output logic        m_axis_tlast
);
    logic [stt_pkg::RES_W-1:0] res_ms_reg;
    logic                      out_valid_reg;
    stt_pkg::res_t             out_reg;
    logic                      out_free;
    logic                      res_load;
    stt_pkg::res_t             res;

    assign out_free = !out_valid_reg || m_axis_tready;

    stt_seq #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (s_axis_tuser),
        .in_task  (s_axis_tdata[7:0]),
        .in_ref   (s_axis_tdata[23:8]),
        .in_dur   (s_axis_tdata[55:24]),
        .tick_res (res_ms_reg),
        .out_free (out_free),
        .res_load (res_load),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ms_reg    <= stt_pkg::RES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                res_ms_reg <= cfg_wdata;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.owner_ref, out_reg.owner_task};
    assign m_axis_tuser  = out_reg.event_res;
    assign m_axis_tlast  = out_reg.last;

endmodule

/* sv/stt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/stt_div.sv */
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
// Depends on stt_pkg.
module stt_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [stt_pkg::DUR_W-1:0]  dividend,
    input  logic [stt_pkg::RES_W-1:0]  divisor,
    output logic                       done,
    output logic [stt_pkg::DUR_W-1:0]  quotient
);
    localparam int CNT_W = $clog2(stt_pkg::DUR_W);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [stt_pkg::DUR_W-1:0]  q_reg, q_next;
    logic [stt_pkg::RES_W-1:0]  rem_reg, rem_next;
    logic [stt_pkg::RES_W-1:0]  d_reg, d_next;
    logic [stt_pkg::RES_W:0]    trial;
    logic [stt_pkg::RES_W:0]    diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        trial     = {rem_reg, q_reg[stt_pkg::DUR_W-1]};
        diff      = trial - {1'b0, d_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            // treat zero resolution as one
            d_next    = (divisor == '0) ? stt_pkg::RES_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = diff[stt_pkg::RES_W-1:0];
                q_next   = {q_reg[stt_pkg::DUR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[stt_pkg::RES_W-1:0];
                q_next   = {q_reg[stt_pkg::DUR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(stt_pkg::DUR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* sv/stt_seq.sv */
// Command sequencer: walks the timer slots one at a time, owns tick count and valid bits.
// Depends on stt_pkg, stt_ram and stt_div.
module stt_seq #(
    parameter int TIMER_SLOTS = stt_pkg::DEFAULT_SLOTS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [stt_pkg::CMD_W-1:0]   in_cmd,
    input  logic [stt_pkg::TASK_W-1:0]  in_task,
    input  logic [stt_pkg::REF_W-1:0]   in_ref,
    input  logic [stt_pkg::DUR_W-1:0]   in_dur,
    input  logic [stt_pkg::RES_W-1:0]   tick_res,
    input  logic                        out_free,
    output logic                        res_load,
    output stt_pkg::res_t               res
);
    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TIMER_SLOTS - 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_T_READ  = 4'd1;
    localparam logic [3:0] ST_T_CHECK = 4'd2;
    localparam logic [3:0] ST_E_FIND  = 4'd3;
    localparam logic [3:0] ST_E_OUT   = 4'd4;
    localparam logic [3:0] ST_S_DIV   = 4'd5;
    localparam logic [3:0] ST_S_FIND  = 4'd6;
    localparam logic [3:0] ST_C_READ  = 4'd7;
    localparam logic [3:0] ST_C_CHECK = 4'd8;
    localparam logic [3:0] ST_RESP    = 4'd9;

    logic [3:0]                   state_reg, state_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [TIMER_SLOTS-1:0]       valid_reg, valid_next;
    logic [TIMER_SLOTS-1:0]       match_reg, match_next;
    logic [stt_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [stt_pkg::TASK_W-1:0]   task_reg, task_next;
    logic [stt_pkg::REF_W-1:0]    ref_reg, ref_next;
    logic [stt_pkg::EV_W-1:0]     code_reg, code_next;
    logic [stt_pkg::TICK_W-1:0]   expiry_reg, expiry_next;

    logic                         rd_en;
    logic                         wr_en;
    stt_pkg::entry_t              rd_data;
    stt_pkg::entry_t              wr_data;
    logic                         div_start;
    logic                         div_done;
    logic [stt_pkg::DUR_W-1:0]    div_q;
    logic [TIMER_SLOTS-1:0]       idx_onehot;
    logic                         rest_empty;
    logic                         idx_at_last;

    stt_ram #(
        .WIDTH ($bits(stt_pkg::entry_t)),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (idx_reg),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    stt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_dur),
        .divisor  (tick_res),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign idx_onehot  = TIMER_SLOTS'(1) << idx_reg;
    assign rest_empty  = ((match_reg & ~idx_onehot) == '0);
    assign idx_at_last = (idx_reg == IDX_LAST);

    assign wr_data.expiry    = expiry_reg;
    assign wr_data.task_id   = task_reg;
    assign wr_data.timer_ref = ref_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        match_next  = match_reg;
        tick_next   = tick_reg;
        task_next   = task_reg;
        ref_next    = ref_reg;
        code_next   = code_reg;
        expiry_next = expiry_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        div_start   = 1'b0;
        res_load    = 1'b0;
        res         = '{event_res: code_reg, owner_task: task_reg,
                        owner_ref: ref_reg, last: 1'b1};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next  = '0;
                    task_next = in_task;
                    ref_next  = in_ref;
                    unique case (in_cmd)
                        stt_pkg::CMD_TICK:
                        begin
                            tick_next  = tick_reg + stt_pkg::TICK_W'(1);
                            state_next = ST_T_READ;
                        end
                        stt_pkg::CMD_START:
                        begin
                            div_start  = 1'b1;
                            state_next = ST_S_DIV;
                        end
                        stt_pkg::CMD_CANCEL:
                        begin
                            state_next = ST_C_READ;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_T_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_T_CHECK;
            end
            ST_T_CHECK:
            begin
                if (valid_reg[idx_reg] && rd_data.expiry == tick_reg)
                begin
                    match_next[idx_reg] = 1'b1;
                    valid_next[idx_reg] = 1'b0;
                end
                if (idx_at_last)
                begin
                    idx_next   = '0;
                    state_next = ST_E_FIND;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_T_READ;
                end
            end
            ST_E_FIND:
            begin
                if (match_reg[idx_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = ST_E_OUT;
                end
                else if (idx_at_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_E_OUT:
            begin
                if (out_free)
                begin
                    res_load            = 1'b1;
                    res                 = '{event_res: stt_pkg::EV_EXPIRED,
                                            owner_task: rd_data.task_id,
                                            owner_ref: rd_data.timer_ref,
                                            last: rest_empty};
                    match_next[idx_reg] = 1'b0;
                    if (rest_empty)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_E_FIND;
                    end
                end
            end
            ST_S_DIV:
            begin
                if (div_done)
                begin
                    expiry_next = tick_reg + div_q;
                    state_next  = ST_S_FIND;
                end
            end
            ST_S_FIND:
            begin
                if (!valid_reg[idx_reg])
                begin
                    wr_en               = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    code_next           = stt_pkg::EV_STARTED;
                    state_next          = ST_RESP;
                end
                else if (idx_at_last)
                begin
                    code_next  = stt_pkg::EV_FULL;
                    state_next = ST_RESP;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_C_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_C_CHECK;
            end
            ST_C_CHECK:
            begin
                if (valid_reg[idx_reg] && rd_data.task_id == task_reg &&
                    rd_data.timer_ref == ref_reg)
                begin
                    valid_next[idx_reg] = 1'b0;
                    code_next           = stt_pkg::EV_CANCELLED;
                    state_next          = ST_RESP;
                end
                else if (idx_at_last)
                begin
                    code_next  = stt_pkg::EV_NOTFOUND;
                    state_next = ST_RESP;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_C_READ;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            valid_reg <= '0;
            match_reg <= '0;
            tick_reg  <= '0;
            code_reg  <= stt_pkg::EV_STARTED;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            match_reg <= match_next;
            tick_reg  <= tick_next;
            code_reg  <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        task_reg   <= task_next;
        ref_reg    <= ref_next;
        expiry_reg <= expiry_next;
    end

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result loaded while output register busy");

    a_start_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.event_res == stt_pkg::EV_STARTED) |=>
        $countones(valid_reg) == $countones($past(valid_reg)))
        else $error("started timer changed slot count after report");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res.event_res == stt_pkg::EV_FULL) |-> (&valid_reg))
        else $error("table full reported with a free slot");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (match_reg == '0))
        else $error("expired entries left unreported");

    a_start_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(idx_reg)])
        else $error("written slot not marked valid");

endmodule
